>>> hdl/prsha_pkg.sv
// shared types and constants for the premultiplied rgba sha-256 hasher
`timescale 1ns / 1ps
`default_nettype none
package prsha_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_pixel;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
      logic        transparent_seen;
      logic        visible_seen;
   } rsp_type;

   // queue entry between front and back: one message word plus marks
   typedef struct packed {
      logic [31:0] word;
      logic        last_pixel;
      logic        transparent;
      logic        visible;
   } beat_type;

   localparam int unsigned QueueDepth = 4;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [15:0] ROUND_BIAS = 16'd127;

   // (c*a+127)/255 via reciprocal: for x < 65536, x/255 = (x*257 + 257) >> 16
   function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
      logic [15:0] x;
      logic [25:0] y;
      begin
         x = c * a + ROUND_BIAS;
         y = {10'd0, x} * 26'd257 + 26'd257;
         premul = y[23:16];
      end
   endfunction

endpackage
`default_nettype wire

>>> hdl/prsha_stream_if.sv
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none
interface prsha_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/prsha_front.sv
// front end: premultiply pixel and queue message words with flags
`timescale 1ns / 1ps
`default_nettype none
module prsha_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   prsha_stream_if.sink              req,
   output prsha_pkg::beat_type       beat_out,
   output logic                      beat_valid,
   input  wire logic                 beat_take
);
   import prsha_pkg::*;

   localparam int unsigned PtrW = $clog2(QueueDepth);

   beat_type           mem_ff [QueueDepth];
   logic [PtrW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]      cnt_ff, cnt_in;
   logic               push;
   beat_type           beat;

   assign req.ready  = (cnt_ff != QueueDepth[PtrW:0]);
   assign push       = req.valid && req.ready;
   assign beat_valid = (cnt_ff != '0);
   assign beat_out   = mem_ff[rd_ff];

   always_comb begin
      beat.word        = {premul(req.payload.red, req.payload.alpha),
                          premul(req.payload.green, req.payload.alpha),
                          premul(req.payload.blue, req.payload.alpha),
                          req.payload.alpha};
      beat.last_pixel  = req.payload.last_pixel;
      beat.transparent = (req.payload.alpha != 8'hff);
      beat.visible     = (req.payload.alpha != 8'h00);
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = beat_take ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, beat_take};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= beat;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

>>> hdl/prsha_back.sv
// back end: block fill, padding, sha-256 rounds and digest output
`timescale 1ns / 1ps
`default_nettype none
module prsha_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire prsha_pkg::beat_type  beat_in,
   input  wire logic                 beat_valid,
   output logic                      beat_take,
   prsha_stream_if.source            rsp
);
   import prsha_pkg::*;

   typedef enum logic [2:0] {
      S_FILL, S_ROUND, S_ADD, S_PAD, S_LEN, S_OUT
   } state_type;

   state_type     state_ff;
   logic [31:0]   h_ff [8];
   logic [31:0]   v_ff [8];
   logic [31:0]   w_ff [16];
   logic [63:0]   total_ff;
   logic [5:0]    rnd_ff;
   logic          trans_ff, vis_ff, fin_ff, lenblk_ff;
   logic [1:0]    idx_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [31:0]   s0, s1, w_new, t1, t2, e, a, wr;
   logic [3:0]    slot;
   logic [63:0]   bits;

   assign beat_take   = (state_ff == S_FILL) && beat_valid;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign slot        = total_ff[5:2];
   assign bits        = {total_ff[60:0], 3'b000};

   always_comb begin
      s0    = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
              ^ (w_ff[1] >> 3);
      s1    = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
              ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      wr    = w_ff[0];
      e     = v_ff[4];
      a     = v_ff[0];
      t1    = v_ff[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & v_ff[5]) ^ (~e & v_ff[6])) + ROUND_K[rnd_ff] + wr;
      t2    = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         h_ff         <= INIT_H;
         total_ff     <= '0;
         rnd_ff       <= '0;
         trans_ff     <= 1'b0;
         vis_ff       <= 1'b0;
         fin_ff       <= 1'b0;
         lenblk_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_FILL: begin
               if (beat_valid) begin
                  w_ff[slot] <= beat_in.word;
                  total_ff   <= total_ff + 64'd4;
                  trans_ff   <= trans_ff | beat_in.transparent;
                  vis_ff     <= vis_ff | beat_in.visible;
                  fin_ff     <= beat_in.last_pixel;
                  lenblk_ff  <= 1'b0;
                  if (slot == 4'd15) begin
                     v_ff     <= h_ff;
                     state_ff <= S_ROUND;
                  end else if (beat_in.last_pixel) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               // marker then zeros; length goes in if room remains
               for (int i = 0; i < 14; i++) begin
                  if (i == int'(slot)) w_ff[i] <= 32'h80000000;
                  else if (i > int'(slot)) w_ff[i] <= '0;
               end
               if (slot < 4'd14) begin
                  w_ff[14]  <= bits[63:32];
                  w_ff[15]  <= bits[31:0];
                  lenblk_ff <= 1'b1;
               end else if (slot == 4'd14) begin
                  w_ff[14] <= 32'h80000000;
                  w_ff[15] <= '0;
               end else begin
                  w_ff[15] <= 32'h80000000;
               end
               v_ff     <= h_ff;
               state_ff <= S_ROUND;
            end
            S_LEN: begin
               for (int i = 0; i < 14; i++) w_ff[i] <= '0;
               w_ff[14]  <= bits[63:32];
               w_ff[15]  <= bits[31:0];
               lenblk_ff <= 1'b1;
               v_ff      <= h_ff;
               state_ff  <= S_ROUND;
            end
            S_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= w_new;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff  <= rnd_ff + 1'b1;
               if (rnd_ff == 6'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (!fin_ff) state_ff <= S_FILL;
               else if (lenblk_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_OUT;
               end else if (slot == 4'd0) state_ff <= S_PAD;
               else state_ff <= S_LEN;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.digest_word       <= {h_ff[{idx_ff, 1'b0}], h_ff[{idx_ff, 1'b1}]};
                  rsp_ff.word_index        <= idx_ff;
                  rsp_ff.last_word         <= (idx_ff == 2'd3);
                  rsp_ff.transparent_seen  <= trans_ff;
                  rsp_ff.visible_seen      <= vis_ff;
                  idx_ff                   <= idx_ff + 1'b1;
                  if (idx_ff == 2'd3) begin
                     h_ff      <= INIT_H;
                     total_ff  <= '0;
                     trans_ff  <= 1'b0;
                     vis_ff    <= 1'b0;
                     fin_ff    <= 1'b0;
                     lenblk_ff <= 1'b0;
                     state_ff  <= S_FILL;
                  end
               end
            end
            default: state_ff <= S_FILL;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> hdl/premultiplied_rgba_sha256.sv
// top level of the premultiplied rgba sha-256 hasher
// req channel: one rgba pixel a beat, last_pixel marks the end of an image
// rsp channel: four 64-bit digest beats per image, word 0 most significant,
// each with the transparency and visibility flags of the whole image
// front end premultiplies colour by alpha and queues message words (4 deep)
// back end runs one sha-256 round a cycle: 64 rounds then an add step
// per 64-byte block of 16 pixels
// last pixel adds padding: in its own block or one extra block, then four output beats
// a stalled rsp holds the back end; the queue keeps taking pixels till full
// synchronous reset clears the control state and loads the initial hash values
`timescale 1ns / 1ps
`default_nettype none
module premultiplied_rgba_sha256 (
   input  wire logic        clock,
   input  wire logic        reset,
   prsha_stream_if.sink     req,
   prsha_stream_if.source   rsp
);
   import prsha_pkg::*;

   beat_type beat;
   logic     beat_valid, beat_take;

   prsha_front u_front (
      .clock, .reset, .req,
      .beat_out(beat), .beat_valid, .beat_take
   );

   prsha_back u_back (
      .clock, .reset,
      .beat_in(beat), .beat_valid, .beat_take, .rsp
   );
endmodule
`default_nettype wire

>>> tb/premultiplied_rgba_sha256_checker.sv
// checker for the premultiplied rgba sha-256 hasher: predicts digests and compares rsp beats
`timescale 1ns / 1ps
`default_nettype none
module premultiplied_rgba_sha256_checker
   import prsha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_payload,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_payload,
   output int               error_count,
   output int               pending_digest_beats
);

   localparam logic [31:0] HASH_START [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic [31:0] hash_state [8];
   logic [31:0] block_words [16];
   logic [63:0] image_bytes;
   logic        seen_transparent;
   logic        seen_visible;
   rsp_type     digest_beats [$];

   function automatic logic [31:0] rot(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
      int unsigned p;
      p = (c * a + 127) / 255;
      return p[7:0];
   endfunction

   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
         t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic absorb_pixel(input req_type px);
      logic [31:0] word;
      logic [63:0] bit_len;
      int          used;
      rsp_type     beat;
      word = {scale_by_alpha(px.red, px.alpha), scale_by_alpha(px.green, px.alpha),
              scale_by_alpha(px.blue, px.alpha), px.alpha};
      if (px.alpha != 8'hff) seen_transparent = 1'b1;
      if (px.alpha != 8'h00) seen_visible = 1'b1;
      block_words[image_bytes[5:2]] = word;
      image_bytes += 64'd4;
      if (image_bytes[5:0] == 6'd0) compress();
      if (!px.last_pixel) return;
      used = int'(image_bytes[5:2]);
      block_words[used] = 32'h80000000;
      for (int i = used + 1; i < 16; i++) block_words[i] = '0;
      if (used >= 14) begin
         compress();
         for (int i = 0; i < 16; i++) block_words[i] = '0;
      end
      bit_len = image_bytes << 3;
      block_words[14] = bit_len[63:32];
      block_words[15] = bit_len[31:0];
      compress();
      for (int k = 0; k < 4; k++) begin
         beat.digest_word = {hash_state[2*k], hash_state[2*k+1]};
         beat.word_index = k[1:0];
         beat.last_word = (k == 3);
         beat.transparent_seen = seen_transparent;
         beat.visible_seen = seen_visible;
         digest_beats.push_back(beat);
      end
      for (int i = 0; i < 8; i++) hash_state[i] = HASH_START[i];
      image_bytes = '0;
      seen_transparent = 1'b0;
      seen_visible = 1'b0;
   endtask

   initial begin
      error_count = 0;
      pending_digest_beats = 0;
      for (int i = 0; i < 8; i++) hash_state[i] = HASH_START[i];
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      image_bytes = '0;
      seen_transparent = 1'b0;
      seen_visible = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (digest_beats.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected rsp beat %h", rsp_payload);
            end else begin
               want = digest_beats.pop_front();
               if (rsp_payload !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"rsp mismatch: expected word %h idx %0d last %b t %b v %b,",
                               " got word %h idx %0d last %b t %b v %b"},
                        want.digest_word, want.word_index, want.last_word,
                        want.transparent_seen, want.visible_seen,
                        rsp_payload.digest_word, rsp_payload.word_index,
                        rsp_payload.last_word, rsp_payload.transparent_seen,
                        rsp_payload.visible_seen);
               end
            end
         end
         if (req_valid && req_ready) absorb_pixel(req_payload);
      end
      pending_digest_beats = digest_beats.size();
   end

endmodule
`default_nettype wire

>>> tb/premultiplied_rgba_sha256_tb.sv
// stimulus and verdict for the premultiplied rgba sha-256 hasher
`timescale 1ns / 1ps
`default_nettype none
module premultiplied_rgba_sha256_tb;
   import prsha_pkg::*;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_digest_beats;
   int   burst_left;
   logic stall_mode;

   prsha_stream_if #(.payload_type(req_type)) req_if ();
   prsha_stream_if #(.payload_type(rsp_type)) rsp_if ();

   premultiplied_rgba_sha256 dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   premultiplied_rgba_sha256_checker digest_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .req_payload(req_if.payload),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .rsp_payload(rsp_if.payload),
      .error_count(error_count),
      .pending_digest_beats(pending_digest_beats)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: alternates stretches of full rate and random stalls
   initial begin
      rsp_if.ready = 1'b0;
      stall_mode = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 40) == 0) stall_mode = ~stall_mode;
         if (stall_mode)
            rsp_if.ready <= ($urandom_range(0, 3) == 0);
         else
            rsp_if.ready <= 1'b1;
      end
   end

   // one pixel beat, with bursty gaps before it
   task automatic send_pixel(input req_type px);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.payload <= px;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_alpha();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_image(input int pixels, input int alpha_kind);
      req_type px;
      for (int i = 0; i < pixels; i++) begin
         px.red = 8'($urandom);
         px.green = 8'($urandom);
         px.blue = 8'($urandom);
         case (alpha_kind)
            0: px.alpha = 8'hff;
            1: px.alpha = 8'h00;
            default: px.alpha = random_alpha();
         endcase
         px.last_pixel = (i == pixels - 1);
         send_pixel(px);
      end
   endtask

   initial begin
      req_type px;
      int      sent;
      int      pixels;
      int      wait_cycles;
      burst_left = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: single-pixel extremes, then a 14-pixel image at a padding boundary
      px = '{red: 8'hff, green: 8'h00, blue: 8'h80, alpha: 8'hff, last_pixel: 1'b1};
      send_pixel(px);
      px = '{red: 8'hff, green: 8'hff, blue: 8'hff, alpha: 8'h00, last_pixel: 1'b1};
      send_pixel(px);
      px = '{red: 8'h00, green: 8'hff, blue: 8'h01, alpha: 8'h01, last_pixel: 1'b1};
      send_pixel(px);
      px = '{red: 8'haa, green: 8'h55, blue: 8'h7f, alpha: 8'h80, last_pixel: 1'b1};
      send_pixel(px);
      send_image(14, 0);
      sent = 18;

      // random images, mostly small, a few crossing one or two blocks
      while (sent < 350) begin
         case ($urandom_range(0, 9))
            0: pixels = $urandom_range(13, 17);
            1: pixels = $urandom_range(28, 34);
            default: pixels = $urandom_range(1, 8);
         endcase
         send_image(pixels, $urandom_range(0, 4));
         sent += pixels;
      end
      req_if.valid <= 1'b0;

      wait_cycles = 0;
      while (pending_digest_beats != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);
      if (error_count == 0 && pending_digest_beats == 0)
         $display("premultiplied_rgba_sha256 test passed");
      else
         $display("premultiplied_rgba_sha256 test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("premultiplied_rgba_sha256 test failed");
      $finish;
   end

endmodule
`default_nettype wire
